// File: sv/sbfr_pkg.sv
// Package for the SBUS frame receiver: frame geometry, register map and
// scaling constants shared by the receiver logic. No dependencies.

package sbfr_pkg;

	localparam int FRAME_BYTES     = 25;
	localparam int ANALOG_CHANNELS = 16;
	localparam int POS_W           = $clog2(FRAME_BYTES);
	localparam int STORE_DEPTH     = 2 ** POS_W;
	localparam int CH_BITS         = 11;
	localparam int BITBUF_W        = CH_BITS + 7;
	localparam int CNT_W           = $clog2(BITBUF_W + 1);
	localparam int CH_W            = $clog2(ANALOG_CHANNELS);

	localparam logic [POS_W-1:0] FIRST_DATA_BYTE = POS_W'(1);
	localparam logic [POS_W-1:0] LAST_BYTE_POS   = POS_W'(FRAME_BYTES - 1);

	localparam int DIGITAL_HIGH_DEF = 2000;
	localparam int DIGITAL_LOW_DEF  = 1000;

	localparam logic [11:0] SCALE_OFFSET = 12'd880;

	localparam logic [4:0] CH_FLAG0 = 5'(ANALOG_CHANNELS);
	localparam logic [4:0] CH_FLAG1 = 5'(ANALOG_CHANNELS + 1);

	localparam logic RESULT_CHANNEL = 1'b0;
	localparam logic RESULT_ERROR   = 1'b1;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_START  = 2'd1;
	localparam logic [1:0] REG_END    = 2'd2;

	localparam logic [15:0] WINDOW_RESET = 16'd3500;
	localparam logic [7:0]  START_RESET  = 8'h0F;
	localparam logic [7:0]  END_RESET    = 8'h00;

endpackage

// File: sv/sbus_frame_receiver.sv
// SBUS frame receiver top level: byte intake, frame store, channel unpacking
// and result output register. Depends on sbfr_pkg.

// Bytes are taken one per cycle while no frame is being decoded or rejected;
// a byte that does not complete a frame does not stall input. The 25 bytes
// of a frame are kept in a 32 x 8 synchronous store. When a good frame
// completes, input is stalled while the store is read back through its single
// read port: each of the 22 analogue data bytes is read and then loaded, each
// of the 18 channel items is output and the flag byte is read, and any output
// stall lengthens the read-back. A frame with a bad end byte yields one error
// item; input stays stalled until the output register takes it. The frame
// counts are captured with each item, so a waiting item keeps its values while
// later bytes are taken. The store needs no clearing pass after reset.
module sbus_frame_receiver
	import sbfr_pkg::*;
#(
	parameter int DIGITAL_HIGH = DIGITAL_HIGH_DEF,
	parameter int DIGITAL_LOW  = DIGITAL_LOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	input  logic [31:0]       arrival_time_us,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              result_kind,
	output logic [4:0]        channel_index,
	output logic [11:0]       channel_value,
	output logic [31:0]       dropped_frames,
	output logic [31:0]       error_frames,
	output logic              last
);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_FETCH   = 8'b0000_0010,
		ST_LOAD    = 8'b0000_0100,
		ST_EMIT    = 8'b0000_1000,
		ST_FLAG_RD = 8'b0001_0000,
		ST_FLAG0   = 8'b0010_0000,
		ST_FLAG1   = 8'b0100_0000,
		ST_ERR     = 8'b1000_0000
	} state_t;

	localparam logic [11:0] VAL_HIGH = 12'(DIGITAL_HIGH);
	localparam logic [11:0] VAL_LOW  = 12'(DIGITAL_LOW);

	state_t               state_q;
	logic [15:0]          window_q;
	logic [7:0]           start_byte_q;
	logic [7:0]           end_byte_q;
	logic [POS_W-1:0]     pos_q;
	logic [31:0]          start_time_q;
	logic [31:0]          dropped_q;
	logic [31:0]          error_q;
	logic [POS_W-1:0]     rd_addr_q;
	logic [BITBUF_W-1:0]  bitbuf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CH_W-1:0]      ch_q;

	logic [7:0]           mem [STORE_DEPTH];
	logic [7:0]           rdata_s1;
	logic                 mem_we;
	logic                 mem_re;

	logic                 out_valid_q;
	logic                 kind_q;
	logic [4:0]           index_q;
	logic [11:0]          value_q;
	logic                 last_q;
	logic [31:0]          drop_out_q;
	logic [31:0]          err_out_q;

	logic                 cfg_wr;
	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;
	logic [31:0]          elapsed;
	logic                 timeout;
	logic [POS_W-1:0]     pos_eff;
	logic                 take;
	logic [CNT_W-1:0]     cnt_after_emit;
	logic [CNT_W-1:0]     cnt_after_load;
	logic [13:0]          v_times5;
	logic [11:0]          analog_value;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && ((state_q == ST_EMIT) || (state_q == ST_FLAG0) ||
		(state_q == ST_FLAG1) || (state_q == ST_ERR));

	assign elapsed = arrival_time_us - start_time_q;
	assign timeout = elapsed > {16'd0, window_q};
	assign pos_eff = (timeout || pos_q > LAST_BYTE_POS) ? '0 : pos_q;
	assign take    = (pos_eff != '0) || (rx_byte == start_byte_q);

	assign mem_we = in_acc && take;
	assign mem_re = (state_q == ST_FETCH) || (state_q == ST_FLAG_RD);

	assign cnt_after_emit = cnt_q - CNT_W'(CH_BITS);
	assign cnt_after_load = cnt_q + CNT_W'(8);
	assign v_times5       = {3'd0, bitbuf_q[CH_BITS-1:0]} +
		{1'b0, bitbuf_q[CH_BITS-1:0], 2'b00};
	assign analog_value   = 12'(v_times5 >> 3) + SCALE_OFFSET;

	always_comb begin
		unique case (paddr[3:2])
			REG_WINDOW: prdata = {16'd0, window_q};
			REG_START:  prdata = {24'd0, start_byte_q};
			REG_END:    prdata = {24'd0, end_byte_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RESET;
			start_byte_q <= START_RESET;
			end_byte_q   <= END_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_WINDOW: window_q     <= pwdata[15:0];
				REG_START:  start_byte_q <= pwdata[7:0];
				REG_END:    end_byte_q   <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos_eff] <= rx_byte;
		end
		if (mem_re) begin
			rdata_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			start_time_q <= '0;
			dropped_q    <= '0;
			error_q      <= '0;
			rd_addr_q    <= '0;
			bitbuf_q     <= '0;
			cnt_q        <= '0;
			ch_q         <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= RESULT_CHANNEL;
			index_q      <= '0;
			value_q      <= '0;
			last_q       <= 1'b0;
			drop_out_q   <= '0;
			err_out_q    <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (out_load) begin
				drop_out_q <= dropped_q;
				err_out_q  <= error_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (timeout) begin
							dropped_q <= dropped_q + 32'd1;
						end
						if (!take) begin
							pos_q <= '0;
						end else if (pos_eff == LAST_BYTE_POS) begin
							pos_q <= '0;
							if (rx_byte != end_byte_q) begin
								error_q <= error_q + 32'd1;
								state_q <= ST_ERR;
							end else begin
								rd_addr_q <= FIRST_DATA_BYTE;
								bitbuf_q  <= '0;
								cnt_q     <= '0;
								ch_q      <= '0;
								state_q   <= ST_FETCH;
							end
						end else begin
							if (pos_eff == '0) begin
								start_time_q <= arrival_time_us;
							end
							pos_q <= pos_eff + POS_W'(1);
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					bitbuf_q  <= bitbuf_q | (BITBUF_W'(rdata_s1) << cnt_q);
					cnt_q     <= cnt_after_load;
					rd_addr_q <= rd_addr_q + POS_W'(1);
					state_q   <= (cnt_after_load >= CNT_W'(CH_BITS)) ? ST_EMIT : ST_FETCH;
				end
				ST_EMIT: begin
					if (out_free) begin
						kind_q      <= RESULT_CHANNEL;
						index_q     <= 5'(ch_q);
						value_q     <= analog_value;
						last_q      <= 1'b0;
						bitbuf_q    <= bitbuf_q >> CH_BITS;
						cnt_q       <= cnt_after_emit;
						ch_q        <= ch_q + CH_W'(1);
						priority if (ch_q == CH_W'(ANALOG_CHANNELS - 1)) begin
							state_q <= ST_FLAG_RD;
						end else if (cnt_after_emit >= CNT_W'(CH_BITS)) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FLAG_RD: begin
					state_q <= ST_FLAG0;
				end
				ST_FLAG0: begin
					if (out_free) begin
						kind_q      <= RESULT_CHANNEL;
						index_q     <= CH_FLAG0;
						value_q     <= rdata_s1[0] ? VAL_HIGH : VAL_LOW;
						last_q      <= 1'b0;
						state_q     <= ST_FLAG1;
					end
				end
				ST_FLAG1: begin
					if (out_free) begin
						kind_q      <= RESULT_CHANNEL;
						index_q     <= CH_FLAG1;
						value_q     <= rdata_s1[1] ? VAL_HIGH : VAL_LOW;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						kind_q      <= RESULT_ERROR;
						index_q     <= '0;
						value_q     <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = kind_q;
	assign channel_index  = index_q;
	assign channel_value  = value_q;
	assign dropped_frames = drop_out_q;
	assign error_frames   = err_out_q;
	assign last           = last_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("frame store read and written in the same cycle");

	a_error_item_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == RESULT_ERROR) |-> (last_q && index_q == '0))
		else $error("error item is not a lone last item");

	a_bitbuf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BITBUF_W))
		else $error("bit buffer count overflow");

	a_pos_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (pos_q == '0))
		else $error("byte position not cleared while decoding");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for sbus_frame_receiver: a directed table and random frame traffic across
// several register settings, every result checked against a local frame decoder or the table.
// Depends on sbfr_pkg and sbus_frame_receiver.

module tb_top
	import sbfr_pkg::*;
();

	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 4000;
	localparam int SETTLE      = 100;

	typedef struct packed {
		logic        kind;
		logic [4:0]  chan;
		logic [11:0] value;
		logic [31:0] dropped;
		logic [31:0] errors;
		logic        is_last;
	} rx_result_t;

	typedef enum logic [1:0] {ST_BYTE, ST_FRAME, ST_PARTIAL} stim_kind_t;
	typedef enum logic [1:0] {DRAIN_FREE, DRAIN_RANDOM, DRAIN_PERIODIC} drain_mode_t;

	typedef struct packed {
		stim_kind_t  kind;
		logic [7:0]  fill;
		logic [7:0]  flags;
		logic [7:0]  tail;
		logic [31:0] t0;
		logic [31:0] step;
		logic [4:0]  count;
		logic        random_fill;
		logic        typed;
		logic [11:0] analog_exp;
		logic [11:0] flag0_exp;
		logic [11:0] flag1_exp;
		logic [31:0] drop_exp;
		logic [31:0] err_exp;
	} stim_row_t;

	localparam stim_row_t DIRECTED [14] = '{
		'{ST_BYTE,  8'h55, 8'h00, 8'h00, 32'd100, 32'd0, 5'd0, 1'b0, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_FRAME, 8'h00, 8'h00, 8'h00, 32'd200, 32'd1, 5'd0, 1'b0, 1'b1,
			12'd880, 12'd1000, 12'd1000, 32'd0, 32'd0},
		'{ST_FRAME, 8'hFF, 8'h03, 8'h00, 32'd1000, 32'd10, 5'd0, 1'b0, 1'b1,
			12'd2159, 12'd2000, 12'd2000, 32'd0, 32'd0},
		'{ST_FRAME, 8'h00, 8'h00, 8'hA5, 32'd2000, 32'd5, 5'd0, 1'b1, 1'b1,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd1},
		'{ST_FRAME, 8'hFF, 8'h01, 8'h00, 32'd3000, 32'd20, 5'd0, 1'b0, 1'b1,
			12'd2159, 12'd2000, 12'd1000, 32'd0, 32'd1},
		'{ST_BYTE,  8'h33, 8'h00, 8'h00, 32'd9000, 32'd0, 5'd0, 1'b0, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_BYTE,  8'h33, 8'h00, 8'h00, 32'd9001, 32'd0, 5'd0, 1'b0, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_PARTIAL, 8'h11, 8'h00, 8'h00, 32'd20000, 32'd3500, 5'd2, 1'b0, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_BYTE,  8'h22, 8'h00, 8'h00, 32'd23501, 32'd0, 5'd0, 1'b0, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_FRAME, 8'hAA, 8'h02, 8'h00, 32'd30000, 32'd1, 5'd0, 1'b0, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_FRAME, 8'h00, 8'h02, 8'h00, 32'hFFFF_FFF0, 32'd1, 5'd0, 1'b1, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_PARTIAL, 8'h00, 8'h00, 8'h00, 32'd100, 32'd1, 5'd12, 1'b1, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_FRAME, 8'h00, 8'h01, 8'h00, 32'd200, 32'd1, 5'd0, 1'b1, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0},
		'{ST_FRAME, 8'h00, 8'hFF, 8'h00, 32'd10000, 32'd1, 5'd0, 1'b0, 1'b0,
			12'd0, 12'd0, 12'd0, 32'd0, 32'd0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        rx_byte = '0;
	logic [31:0]       arrival_time_us = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              result_kind;
	logic [4:0]        channel_index;
	logic [11:0]       channel_value;
	logic [31:0]       dropped_frames;
	logic [31:0]       error_frames;
	logic              last;

	sbus_frame_receiver uut (.*);

	// Local copy of the receiver state and its registers.
	logic [15:0] cfg_window = WINDOW_RESET;
	logic [7:0]  cfg_start = START_RESET;
	logic [7:0]  cfg_end = END_RESET;
	int          frame_pos = 0;
	logic [7:0]  frame_buf [FRAME_BYTES];
	logic [31:0] frame_t0 = '0;
	logic [31:0] drop_count = '0;
	logic [31:0] err_count = '0;

	rx_result_t  outputs_due [$];
	rx_result_t  decoded_now [$];
	rx_result_t  typed_results [$];

	int          mismatches = 0;
	int          bytes_in = 0;
	int          results_checked = 0;
	int          frames_decoded = 0;
	int          settings_used = 1;
	int          burst_left = 0;
	bit          steady_sender = 1'b0;
	logic [31:0] now_us = '0;
	int          holds_asked = 0;
	int          holds_done = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic decode_rx_byte(input logic [7:0] b, input logic [31:0] t);
		logic [31:0]  elapsed;
		logic [175:0] stream;
		logic [10:0]  raw;
		logic [31:0]  scaled;
		rx_result_t   r;
		int           i;
		decoded_now.delete();
		elapsed = t - frame_t0;
		if (elapsed > 32'(cfg_window)) begin
			frame_pos = 0;
			drop_count++;
		end
		if (frame_pos == 0) begin
			if (b != cfg_start)
				return;
			frame_t0 = t;
		end
		frame_buf[frame_pos] = b;
		frame_pos++;
		if (frame_pos < FRAME_BYTES)
			return;
		frame_pos = 0;
		r.dropped = drop_count;
		if (frame_buf[FRAME_BYTES-1] != cfg_end) begin
			err_count++;
			r.kind = RESULT_ERROR;
			r.chan = 5'd0;
			r.value = 12'd0;
			r.errors = err_count;
			r.is_last = 1'b1;
			decoded_now.push_back(r);
			return;
		end
		frames_decoded++;
		r.errors = err_count;
		r.kind = RESULT_CHANNEL;
		r.is_last = 1'b0;
		for (i = 1; i <= 22; i++)
			stream[8*(i-1) +: 8] = frame_buf[i];
		for (i = 0; i < ANALOG_CHANNELS; i++) begin
			raw = stream[11*i +: 11];
			scaled = (32'd5 * 32'(raw)) / 32'd8 + 32'd880;
			r.chan = 5'(i);
			r.value = scaled[11:0];
			decoded_now.push_back(r);
		end
		r.chan = CH_FLAG0;
		r.value = frame_buf[23][0] ? 12'(DIGITAL_HIGH_DEF) : 12'(DIGITAL_LOW_DEF);
		decoded_now.push_back(r);
		r.chan = CH_FLAG1;
		r.value = frame_buf[23][1] ? 12'(DIGITAL_HIGH_DEF) : 12'(DIGITAL_LOW_DEF);
		r.is_last = 1'b1;
		decoded_now.push_back(r);
	endtask

	// Called just after a rising edge; returns at the edge where the item is taken.
	task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
		int gap;
		if (burst_left == 0) begin
			gap = steady_sender ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte <= b;
		arrival_time_us <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_in++;
		decode_rx_byte(b, t);
		if (typed_results.size() != 0 && decoded_now.size() != 0) begin
			foreach (typed_results[i])
				outputs_due.push_back(typed_results[i]);
			typed_results.delete();
		end else begin
			foreach (decoded_now[i])
				outputs_due.push_back(decoded_now[i]);
		end
	endtask

	task automatic send_frame(input logic [7:0] flags, input logic [7:0] tail, input int n,
			input logic [7:0] fill, input bit random_fill, input logic [31:0] t0,
			input int step_lo, input int step_hi);
		logic [7:0] b;
		int         k;
		now_us = t0;
		for (k = 0; k < n; k++) begin
			if (k > 0)
				now_us += $urandom_range(step_lo, step_hi);
			if (k == 0)
				b = cfg_start;
			else if (k == FRAME_BYTES - 1)
				b = tail;
			else if (k == FRAME_BYTES - 2)
				b = flags;
			else if (!random_fill)
				b = fill;
			else if ($urandom_range(0, 7) == 0)
				b = cfg_start;
			else
				b = 8'($urandom);
			send_byte(b, now_us);
		end
	endtask

	task automatic apb_cycle(input logic write, input logic [1:0] reg_id,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= ADDR_W'({reg_id, 2'b00});
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input logic [1:0] reg_id, input logic [31:0] want);
		logic [31:0] got;
		apb_cycle(1'b0, reg_id, 32'd0, got);
		if (got !== want) begin
			$display("%0t: register %0d expected %0h, got %0h", $time, reg_id, want, got);
			mismatches++;
		end
	endtask

	task automatic program_register(input logic [1:0] reg_id, input logic [31:0] value);
		logic [31:0] unused;
		apb_cycle(1'b1, reg_id, value, unused);
		check_register(reg_id, value);
	endtask

	task automatic set_config(input logic [15:0] window, input logic [7:0] sb,
			input logic [7:0] eb);
		in_valid <= 1'b0;
		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		program_register(REG_WINDOW, {16'd0, window});
		program_register(REG_START, {24'd0, sb});
		program_register(REG_END, {24'd0, eb});
		cfg_window = window;
		cfg_start = sb;
		cfg_end = eb;
		settings_used++;
	endtask

	task automatic run_random_phase(input int goal, input bit squeeze);
		int         first;
		int         seq;
		int         pick;
		int         span;
		int         n;
		logic [7:0] tail;
		first = bytes_in;
		seq = 0;
		if (squeeze)
			holds_asked++;
		while (bytes_in - first < goal) begin
			steady_sender = ($urandom_range(0, 4) == 0);
			span = int'(cfg_window) / 30;
			if ($urandom_range(0, 19) == 0)
				now_us = $urandom;
			pick = (seq == 0) ? 0 : $urandom_range(0, 99);
			if (pick < 65) begin
				tail = ($urandom_range(0, 99) < 85) ? cfg_end : 8'($urandom);
				send_frame(8'($urandom), tail, FRAME_BYTES, 8'h00, 1'b1,
					now_us + $urandom_range(0, 4 * span), 0, span);
			end else if (pick < 80) begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					now_us += $urandom_range(0, 2 * int'(cfg_window));
					send_byte(8'($urandom), now_us);
				end
			end else begin
				send_frame(8'($urandom), 8'($urandom), $urandom_range(1, 23), 8'h00, 1'b1,
					now_us + $urandom_range(0, span), 0, span);
				now_us += 32'(cfg_window) + 32'd1 + $urandom_range(0, 50);
			end
			seq++;
		end
	endtask

	task check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : drain
		rx_result_t         want;
		static drain_mode_t mode = DRAIN_FREE;
		static int          mode_left = 0;
		static int          hold_left = 0;
		static int          cyc = 0;
		cyc++;
		if (arst_n && out_valid && !out_stall) begin
			if (outputs_due.size() == 0) begin
				$display("%0t: unexpected result, channel %0d value %0d kind %0d", $time,
					channel_index, channel_value, result_kind);
				mismatches++;
			end else begin
				want = outputs_due.pop_front();
				results_checked++;
				check_field("result_kind", 32'(want.kind), 32'(result_kind));
				check_field("channel_index", 32'(want.chan), 32'(channel_index));
				check_field("channel_value", 32'(want.value), 32'(channel_value));
				check_field("dropped_frames", want.dropped, dropped_frames);
				check_field("error_frames", want.errors, error_frames);
				check_field("last", 32'(want.is_last), 32'(last));
			end
		end
		if (holds_asked != holds_done) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				mode = drain_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(50, 250);
			end
			mode_left--;
			case (mode)
				DRAIN_FREE: out_stall <= 1'b0;
				DRAIN_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
				default: out_stall <= ((cyc % 7) < 3);
			endcase
		end
	end

	always @(posedge clk) begin : watchdog
		static int quiet = 0;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet == IDLE_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
			$display("sbus_frame_receiver regression: fail");
			$finish;
		end
	end

	initial begin
		stim_row_t  row;
		rx_result_t r;
		int         i;
		int         ch;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_register(REG_WINDOW, {16'd0, WINDOW_RESET});
		check_register(REG_START, {24'd0, START_RESET});
		check_register(REG_END, {24'd0, END_RESET});

		for (i = 0; i < $size(DIRECTED); i++) begin
			row = DIRECTED[i];
			steady_sender = (i % 3 == 0);
			if (row.typed) begin
				r.dropped = row.drop_exp;
				r.errors = row.err_exp;
				if (row.tail != cfg_end) begin
					r.kind = RESULT_ERROR;
					r.chan = 5'd0;
					r.value = 12'd0;
					r.is_last = 1'b1;
					typed_results.push_back(r);
				end else begin
					for (ch = 0; ch < ANALOG_CHANNELS + 2; ch++) begin
						r.kind = RESULT_CHANNEL;
						r.chan = 5'(ch);
						r.value = (ch < ANALOG_CHANNELS) ? row.analog_exp :
							(ch == ANALOG_CHANNELS) ? row.flag0_exp : row.flag1_exp;
						r.is_last = (ch == ANALOG_CHANNELS + 1);
						typed_results.push_back(r);
					end
				end
			end
			case (row.kind)
				ST_BYTE: begin
					now_us = row.t0;
					send_byte(row.fill, row.t0);
				end
				default: begin
					send_frame(row.flags, row.tail,
						(row.kind == ST_PARTIAL) ? int'(row.count) : FRAME_BYTES,
						row.fill, row.random_fill, row.t0, int'(row.step), int'(row.step));
				end
			endcase
			typed_results.delete();
		end

		run_random_phase(6, 1'b1);
		set_config(16'hFFFF, 8'hFF, 8'hFF);
		run_random_phase(6, 1'b0);
		set_config(16'h0000, 8'h00, 8'h7E);
		run_random_phase(6, 1'b0);
		set_config(16'($urandom_range(1, 8000)), 8'($urandom), 8'($urandom));
		run_random_phase(6, 1'b0);
		set_config(WINDOW_RESET, START_RESET, END_RESET);
		run_random_phase(6, 1'b1);

		in_valid <= 1'b0;
		while (outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d bytes under %0d register settings; checked %0d results.",
			bytes_in, settings_used, results_checked);
		$display("Decoded %0d good frames, rejected %0d, counted %0d timeouts.",
			frames_decoded, err_count, drop_count);
		if (mismatches == 0 && outputs_due.size() == 0)
			$display("sbus_frame_receiver regression: pass");
		else
			$display("sbus_frame_receiver regression: fail");
		$finish;
	end

endmodule

// File: sim.f
sv/sbfr_pkg.sv
sv/sbus_frame_receiver.sv
bench/tb_top.sv
